FILE: src/rmld_pkg.sv
package rmld_pkg;

    // Field widths
    localparam int unsigned ModeW   = 4;
    localparam int unsigned DriveW  = 2;
    localparam int unsigned AccelW  = 16;
    localparam int unsigned LimitW  = 15;
    localparam int unsigned LightW  = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 16;

    // Mode codes
    localparam logic [ModeW-1:0] M_PAUSE       = 4'd0;
    localparam logic [ModeW-1:0] M_NORMAL      = 4'd1;
    localparam logic [ModeW-1:0] M_RISE        = 4'd2;
    localparam logic [ModeW-1:0] M_SETTLE_UP   = 4'd3;
    localparam logic [ModeW-1:0] M_FALL        = 4'd4;
    localparam logic [ModeW-1:0] M_LIFTED      = 4'd5;
    localparam logic [ModeW-1:0] M_LOWER       = 4'd6;
    localparam logic [ModeW-1:0] M_SETTLE_DOWN = 4'd7;
    localparam logic [ModeW-1:0] M_STOP_LOWER  = 4'd8;
    localparam logic [ModeW-1:0] M_STOP        = 4'd9;
    localparam logic [ModeW-1:0] M_SLOW        = 4'd10;

    // Drive levels in halves
    localparam logic [DriveW-1:0] DRIVE_ZERO = 2'd0;
    localparam logic [DriveW-1:0] DRIVE_HALF = 2'd1;
    localparam logic [DriveW-1:0] DRIVE_FULL = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_ACCEL_LIMIT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_DARK_LEVEL  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DIM_LEVEL   = 2'd2;

    // Reset values
    localparam logic [LimitW-1:0] ACCEL_LIMIT_RST = 15'd1000;
    localparam logic [LightW-1:0] DARK_LEVEL_RST  = 16'd1000;
    localparam logic [LightW-1:0] DIM_LEVEL_RST   = 16'd4000;

    typedef struct packed {
        logic                     start_pressed;
        logic                     pause_pressed;
        logic signed [AccelW-1:0] accel_vertical;
        logic                     bumped;
        logic [LightW-1:0]        light_level;
    } t_in_item;

    typedef struct packed {
        logic [ModeW-1:0]  mode;
        logic [DriveW-1:0] drive_halves;
    } t_out_item;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [CfgDatW-1:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic [LimitW-1:0] accel_limit;
        logic [LightW-1:0] dark_level;
        logic [LightW-1:0] dim_level;
    } t_cfg_regs;

    function automatic logic [DriveW-1:0] drive_of(input logic [ModeW-1:0] mode);
        logic [DriveW-1:0] d;
        d = DRIVE_ZERO;
        if (mode == M_NORMAL) begin
            d = DRIVE_FULL;
        end else if (mode == M_SLOW) begin
            d = DRIVE_HALF;
        end
        return d;
    endfunction

endpackage

FILE: src/rmld_in_if.sv
interface rmld_in_if
    import rmld_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/rmld_out_if.sv
interface rmld_out_if
    import rmld_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/rmld_cfg_if.sv
interface rmld_cfg_if
    import rmld_pkg::*;
;
    logic       valid;
    logic       ready;
    t_cfg_write payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/rmld_next.sv
// Next-mode decision for one sensor snapshot.
module rmld_next
    import rmld_pkg::*;
(
    input  logic [ModeW-1:0]  i_mode,
    input  t_in_item          i_item,
    input  t_cfg_regs         i_cfg,
    output logic [ModeW-1:0]  o_next_mode
);

    logic signed [AccelW:0] acc_ext;
    logic signed [AccelW:0] lim_pos;
    logic signed [AccelW:0] lim_neg;
    logic                   up;
    logic                   down;
    logic                   settled;
    logic [ModeW-1:0]       drive_nx;

    assign acc_ext = {i_item.accel_vertical[AccelW-1], i_item.accel_vertical};
    assign lim_pos = $signed({2'b00, i_cfg.accel_limit});
    assign lim_neg = -lim_pos;
    assign up      = acc_ext > lim_pos;
    assign down    = acc_ext < lim_neg;
    assign settled = !up && !down;

    always_comb begin
        if (up) begin
            drive_nx = M_RISE;
        end else if (i_item.bumped || (i_item.light_level < i_cfg.dark_level)) begin
            drive_nx = M_STOP;
        end else if (i_item.light_level < i_cfg.dim_level) begin
            drive_nx = M_SLOW;
        end else begin
            drive_nx = M_NORMAL;
        end
    end

    always_comb begin
        o_next_mode = i_mode;
        if (i_mode == M_PAUSE || i_mode > M_SLOW) begin
            o_next_mode = i_item.start_pressed ? M_NORMAL : M_PAUSE;
        end else if (i_item.pause_pressed) begin
            o_next_mode = M_PAUSE;
        end else begin
            unique case (i_mode) inside
                M_NORMAL, M_STOP, M_SLOW: begin
                    o_next_mode = drive_nx;
                end
                M_RISE: begin
                    if (settled) o_next_mode = M_SETTLE_UP;
                end
                M_SETTLE_UP: begin
                    if (down) o_next_mode = M_FALL;
                    else if (up) o_next_mode = M_NORMAL;
                end
                M_FALL: begin
                    if (settled) o_next_mode = M_LIFTED;
                end
                M_LIFTED: begin
                    if (down) o_next_mode = M_LOWER;
                end
                M_LOWER: begin
                    if (settled) o_next_mode = M_SETTLE_DOWN;
                end
                M_SETTLE_DOWN: begin
                    if (up) o_next_mode = M_STOP_LOWER;
                    else if (down) o_next_mode = M_LIFTED;
                end
                M_STOP_LOWER: begin
                    if (settled) o_next_mode = M_NORMAL;
                end
                default: begin
                    o_next_mode = M_PAUSE;
                end
            endcase
        end
    end

endmodule

FILE: src/robot_mode_lift_detect_fsm_top.sv
// Robot mode controller with lift detection. Each transfer on i_in is one
// sensor snapshot (buttons, signed vertical acceleration, bump flag, light
// level); each snapshot yields exactly one transfer on o_out carrying the mode
// entered and its drive level in halves (2 in normal, 1 in slow, 0 otherwise).
// Snapshots are captured in an input register and the next mode is computed
// from it combinationally and stored with the result in an output register,
// and one snapshot is taken every cycle as long as o_out is drained; the
// only limit on rate is the mode update loop, closed through the mode
// register. The configuration registers (accel limit, dark and dim light
// levels) are written through i_cfg, which is always ready; write them
// only while no snapshot is in flight. After reset the mode is pause and
// the registers hold 1000, 1000 and 4000.
module robot_mode_lift_detect_fsm_top
    import rmld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    rmld_in_if.sink   i_in,
    rmld_out_if.source o_out,
    rmld_cfg_if.sink  i_cfg
);

    // Configuration registers
    t_cfg_regs r_cfg;

    // Input register stage
    logic     r_in_valid;
    t_in_item r_in_item;

    // Mode state and output register
    logic [ModeW-1:0] r_mode;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic             advance;
    logic [ModeW-1:0] n_mode;

    // Config writes are accepted every cycle; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_limit <= ACCEL_LIMIT_RST;
            r_cfg.dark_level  <= DARK_LEVEL_RST;
            r_cfg.dim_level   <= DIM_LEVEL_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                CFG_ACCEL_LIMIT: r_cfg.accel_limit <= i_cfg.payload.data[LimitW-1:0];
                CFG_DARK_LEVEL:  r_cfg.dark_level  <= i_cfg.payload.data[LightW-1:0];
                CFG_DIM_LEVEL:   r_cfg.dim_level   <= i_cfg.payload.data[LightW-1:0];
                default: ;
            endcase
        end
    end

    // Advance the held snapshot when the output register is free or being
    // drained this cycle.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    rmld_next u_next (
        .i_mode      (r_mode),
        .i_item      (r_in_item),
        .i_cfg       (r_cfg),
        .o_next_mode (n_mode)
    );

    // Capture a snapshot on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.payload;
        end
    end

    // Update the mode and load the result together; hold both on a stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_PAUSE;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_mode      <= n_mode;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item.mode         <= n_mode;
            r_out_item.drive_halves <= drive_of(n_mode);
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

endmodule

FILE: dv/tb_robot_mode_lift_detect_fsm_top.sv
module tb_robot_mode_lift_detect_fsm_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rmld_pkg::*;

    // Give up well past the slowest legal run: ~800 snapshots, each waiting
    // out the longest source gap, the longest sink stall and the pipeline.
    localparam int CycleLimit  = 100000;
    // Edges to let pass after the last result before touching config.
    localparam int DrainCycles = 4;

    // Class of a vertical acceleration sample against the current limit.
    typedef enum logic [1:0] {
        ACC_UP,
        ACC_DOWN,
        ACC_FLAT
    } t_accel_kind;

    logic i_clk;
    logic i_rst_n;

    rmld_in_if  in_if ();
    rmld_out_if out_if ();
    rmld_cfg_if cfg_if ();

    robot_mode_lift_detect_fsm_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predictor state: mode register and the three thresholds.
    logic [ModeW-1:0]  mdl_mode;
    logic [LimitW-1:0] mdl_accel_limit;
    logic [LightW-1:0] mdl_dark_level;
    logic [LightW-1:0] mdl_dim_level;

    t_in_item  snapshot_q[$];     // snapshots waiting to be driven
    t_out_item mode_result_q[$];  // predicted mode/drive results, oldest first

    int src_gap_max   = 6;
    int snk_stall_max = 6;
    int src_gap       = 0;
    int snk_stall     = 0;
    int n_errors      = 0;
    int cycle_cnt     = 0;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advance the mode predictor by one accepted snapshot and queue the
    // result it must produce.
    task automatic predict_mode(input t_in_item s);
        int               acc;
        int               lim;
        logic             rising;
        logic             falling;
        logic             level;
        logic [ModeW-1:0] nxt;
        t_out_item        res;
        acc     = int'($signed(s.accel_vertical));
        lim     = int'(mdl_accel_limit);
        rising  = acc > lim;
        falling = acc < -lim;
        level   = !rising && !falling;
        nxt     = mdl_mode;
        if (mdl_mode == M_PAUSE || mdl_mode > M_SLOW) begin
            // Pause ignores the pause button; only start leaves it.
            nxt = s.start_pressed ? M_NORMAL : M_PAUSE;
        end else if (s.pause_pressed) begin
            nxt = M_PAUSE;
        end else begin
            case (mdl_mode) inside
                M_NORMAL, M_STOP, M_SLOW: begin
                    if (rising) begin
                        nxt = M_RISE;
                    end else if (s.bumped || s.light_level < mdl_dark_level) begin
                        nxt = M_STOP;
                    end else if (s.light_level < mdl_dim_level) begin
                        nxt = M_SLOW;
                    end else begin
                        nxt = M_NORMAL;
                    end
                end
                M_RISE:        if (level) nxt = M_SETTLE_UP;
                M_SETTLE_UP: begin
                    if (falling) begin
                        nxt = M_FALL;
                    end else if (rising) begin
                        nxt = M_NORMAL;
                    end
                end
                M_FALL:        if (level) nxt = M_LIFTED;
                M_LIFTED:      if (falling) nxt = M_LOWER;
                M_LOWER:       if (level) nxt = M_SETTLE_DOWN;
                M_SETTLE_DOWN: begin
                    if (rising) begin
                        nxt = M_STOP_LOWER;
                    end else if (falling) begin
                        nxt = M_LIFTED;
                    end
                end
                M_STOP_LOWER:  if (level) nxt = M_NORMAL;
                default:       nxt = M_PAUSE;
            endcase
        end
        mdl_mode = nxt;
        res.mode = nxt;
        case (nxt)
            M_NORMAL: res.drive_halves = DRIVE_FULL;
            M_SLOW:   res.drive_halves = DRIVE_HALF;
            default:  res.drive_halves = DRIVE_ZERO;
        endcase
        mode_result_q.push_back(res);
    endtask

    task automatic push_snapshot(input logic start, input logic pause, input int acc,
                                 input logic bump, input logic [LightW-1:0] light);
        t_in_item s;
        s.start_pressed  = start;
        s.pause_pressed  = pause;
        s.accel_vertical = acc[AccelW-1:0];
        s.bumped         = bump;
        s.light_level    = light;
        snapshot_q.push_back(s);
    endtask

    // Draw a sample of the given class against the current limit, often on
    // the edge of the band. With the limit at its top nothing can rise, so
    // fall back to a settled sample.
    function automatic int accel_for(input t_accel_kind k);
        int lim;
        int mag;
        lim = int'(mdl_accel_limit);
        if (k == ACC_UP && lim < 32767) begin
            if ($urandom_range(3, 0) == 0) return lim + 1;
            return int'($urandom_range(32767, lim + 1));
        end
        if (k == ACC_DOWN) begin
            mag = ($urandom_range(3, 0) == 0) ? lim + 1 : int'($urandom_range(32768, lim + 1));
            return -mag;
        end
        case ($urandom_range(5, 0))
            0:       return lim;
            1:       return -lim;
            2:       return 0;
            default: return int'($urandom_range(2 * lim, 0)) - lim;
        endcase
    endfunction

    // Light level aimed at the dark and dim thresholds and the rails.
    function automatic logic [LightW-1:0] pick_light();
        case ($urandom_range(7, 0))
            0:       return mdl_dark_level - 1'b1;
            1:       return mdl_dark_level;
            2:       return mdl_dim_level - 1'b1;
            3:       return mdl_dim_level;
            4:       return '0;
            5:       return '1;
            default: return LightW'($urandom_range(65535, 0));
        endcase
    endfunction

    // Mostly lift-and-set-down runs with random content, some aborted
    // early or bouncing back to lifted; the rest is unshaped noise.
    task automatic gen_traffic(input int n);
        t_accel_kind path[$];
        int          made;
        int          reps;
        made = 0;
        while (made < n) begin
            if ($urandom_range(9, 0) < 3) begin
                push_snapshot(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                              int'($urandom_range(65535, 0)), 1'($urandom_range(1, 0)),
                              LightW'($urandom_range(65535, 0)));
                made++;
            end else begin
                case ($urandom_range(3, 0))
                    0:       path = '{ACC_UP, ACC_FLAT, ACC_UP};
                    1:       path = '{ACC_UP, ACC_FLAT, ACC_DOWN, ACC_FLAT, ACC_DOWN, ACC_FLAT,
                                      ACC_DOWN, ACC_DOWN, ACC_FLAT, ACC_UP, ACC_FLAT};
                    default: path = '{ACC_UP, ACC_FLAT, ACC_DOWN, ACC_FLAT, ACC_DOWN,
                                      ACC_FLAT, ACC_UP, ACC_FLAT};
                endcase
                // Lead in with start held so a paused controller gets going.
                push_snapshot(1'b1, 1'b0, accel_for(ACC_FLAT), $urandom_range(4, 0) == 0,
                              pick_light());
                made++;
                foreach (path[i]) begin
                    reps = ($urandom_range(4, 0) == 0) ? 2 : 1;
                    repeat (reps) begin
                        push_snapshot(1'($urandom_range(1, 0)), $urandom_range(39, 0) == 0,
                                      accel_for(path[i]), $urandom_range(4, 0) == 0,
                                      pick_light());
                        made++;
                    end
                end
            end
        end
    endtask

    // Call at a rising edge; leaves valid high so back-to-back writes
    // stream. Drop valid after the last one.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= t_cfg_write'{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_ACCEL_LIMIT: mdl_accel_limit = val[LimitW-1:0];
            CFG_DARK_LEVEL:  mdl_dark_level  = val;
            CFG_DIM_LEVEL:   mdl_dim_level   = val;
            default: ;
        endcase
    endtask

    // Hold until every snapshot is sent and every result is back. Check on
    // the falling edge, when the driver and monitor have settled.
    task automatic wait_idle();
        while (snapshot_q.size() != 0 || in_if.valid || mode_result_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Snapshot driver: on each transfer, advance the predictor and draw the
    // gap before the next snapshot. At most one assignment to valid per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_mode(in_if.payload);
                src_gap = $urandom_range(src_gap_max, 0);
            end
            if (!in_if.valid || in_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_if.valid <= 1'b0;
                end else if (snapshot_q.size() != 0) begin
                    in_if.valid   <= 1'b1;
                    in_if.payload <= snapshot_q.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest prediction, then
    // draw a stall before taking the next one.
    always @(posedge i_clk) begin : p_monitor
        t_out_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            snk_stall = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (mode_result_q.size() == 0) begin
                    $display("%0t: unexpected result: mode %0d drive %0d", $time,
                             out_if.payload.mode, out_if.payload.drive_halves);
                    n_errors++;
                end else begin
                    want = mode_result_q.pop_front();
                    if (out_if.payload.mode !== want.mode) begin
                        $display("%0t: mode mismatch: expected %0d, got %0d", $time,
                                 want.mode, out_if.payload.mode);
                        n_errors++;
                    end
                    if (out_if.payload.drive_halves !== want.drive_halves) begin
                        $display("%0t: drive mismatch: expected %0d, got %0d", $time,
                                 want.drive_halves, out_if.payload.drive_halves);
                        n_errors++;
                    end
                end
                snk_stall = $urandom_range(snk_stall_max, 0);
            end
            if (snk_stall > 0) begin
                snk_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends up here.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     mode_result_q.size());
            $display("[robot_mode_lift_detect_fsm_top] ERROR");
            $finish;
        end
    end

    initial begin
        // Drive every input to a known value before the first edge.
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        out_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        i_rst_n        = 1'b0;

        mdl_mode        = M_PAUSE;
        mdl_accel_limit = ACCEL_LIMIT_RST;
        mdl_dark_level  = DARK_LEVEL_RST;
        mdl_dim_level   = DIM_LEVEL_RST;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk at reset thresholds (limit 1000, dark 1000, dim 4000).
        // Pause holds even with the pause button and a rising sample.
        push_snapshot(1'b0, 1'b1, 2000, 1'b1, 16'd0);
        push_snapshot(1'b1, 1'b0, 0, 1'b0, 16'hFFFF);       // normal
        push_snapshot(1'b0, 1'b0, 0, 1'b0, 16'd3999);       // slow
        push_snapshot(1'b0, 1'b0, 0, 1'b0, 16'd999);        // stop on dark
        push_snapshot(1'b0, 1'b0, 0, 1'b1, 16'hFFFF);       // stop on bump
        push_snapshot(1'b0, 1'b0, 0, 1'b0, 16'd4000);       // normal, dim boundary
        push_snapshot(1'b0, 1'b0, 1000, 1'b0, 16'd1000);    // at the limit: no rise
        push_snapshot(1'b0, 1'b0, 1001, 1'b0, 16'hFFFF);    // rise
        push_snapshot(1'b0, 1'b0, 32767, 1'b0, 16'hFFFF);   // still rising
        push_snapshot(1'b0, 1'b0, -1000, 1'b0, 16'hFFFF);   // settle up
        push_snapshot(1'b0, 1'b0, -1001, 1'b1, 16'd0);      // fall
        push_snapshot(1'b0, 1'b0, -32768, 1'b0, 16'hFFFF);  // still falling
        push_snapshot(1'b0, 1'b0, 1000, 1'b0, 16'd0);       // lifted
        push_snapshot(1'b0, 1'b0, -32768, 1'b0, 16'd0);     // lower
        push_snapshot(1'b0, 1'b0, 0, 1'b0, 16'd0);          // settle down
        push_snapshot(1'b0, 1'b0, -2000, 1'b0, 16'd0);      // back to lifted
        push_snapshot(1'b0, 1'b0, -1001, 1'b0, 16'd0);      // lower
        push_snapshot(1'b0, 1'b0, 5, 1'b0, 16'd0);          // settle down
        push_snapshot(1'b0, 1'b0, 2000, 1'b0, 16'd0);       // stop lowering
        push_snapshot(1'b0, 1'b0, -1, 1'b0, 16'hFFFF);      // normal
        push_snapshot(1'b0, 1'b0, 1500, 1'b0, 16'hFFFF);    // rise
        push_snapshot(1'b0, 1'b0, 0, 1'b0, 16'hFFFF);       // settle up
        push_snapshot(1'b0, 1'b0, 3000, 1'b0, 16'hFFFF);    // abort to normal
        push_snapshot(1'b0, 1'b0, 1001, 1'b0, 16'hFFFF);    // rise
        push_snapshot(1'b1, 1'b1, 0, 1'b0, 16'hFFFF);       // pause overrides
        push_snapshot(1'b1, 1'b1, 0, 1'b0, 16'hFFFF);       // start wins in pause
        gen_traffic(120);
        wait_idle();

        // Zero limit, written with bit 15 set so the write must drop it;
        // only an exact zero counts as settled. Run without any idling.
        write_reg(CFG_ACCEL_LIMIT, 16'h8000);
        write_reg(CFG_DARK_LEVEL, 16'h0000);
        write_reg(CFG_DIM_LEVEL, 16'hFFFF);
        cfg_if.valid  <= 1'b0;
        src_gap_max   = 0;
        snk_stall_max = 0;
        gen_traffic(120);
        wait_idle();

        // Widest limit: nothing can rise. Stall the sink only.
        write_reg(CFG_ACCEL_LIMIT, 16'h7FFF);
        write_reg(CFG_DARK_LEVEL, 16'hFFFF);
        write_reg(CFG_DIM_LEVEL, 16'h0000);
        cfg_if.valid  <= 1'b0;
        src_gap_max   = 0;
        snk_stall_max = 6;
        gen_traffic(120);
        wait_idle();

        // Random settings, random idling on both sides.
        for (int p = 0; p < 3; p++) begin
            write_reg(CFG_ACCEL_LIMIT, ($urandom_range(1, 0) != 0) ?
                      CfgDatW'($urandom_range(4000, 0)) : CfgDatW'($urandom_range(65535, 0)));
            write_reg(CFG_DARK_LEVEL, CfgDatW'($urandom_range(65535, 0)));
            write_reg(CFG_DIM_LEVEL, CfgDatW'($urandom_range(65535, 0)));
            cfg_if.valid  <= 1'b0;
            src_gap_max   = $urandom_range(6, 0);
            snk_stall_max = $urandom_range(6, 0);
            gen_traffic(130);
            wait_idle();
        end

        if (n_errors == 0) begin
            $display("[robot_mode_lift_detect_fsm_top] OK");
        end else begin
            $display("[robot_mode_lift_detect_fsm_top] ERROR");
        end
        $finish;
    end

endmodule
